FILE: sv/mexp_pkg.sv
package mexp_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WIDTH - 1);

    typedef logic [WIDTH-1:0] word_t;

    typedef struct packed {
        word_t base_value;
        word_t exponent;
        word_t modulus;
    } mexp_in_t;

    typedef struct packed {
        word_t power_result;
        logic  zero_modulus_error;
    } mexp_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } state_t;

endpackage

FILE: sv/mexp_in_if.sv
interface mexp_in_if import mexp_pkg::*; ();

    logic     valid;
    logic     ready;
    mexp_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

FILE: sv/mexp_out_if.sv
interface mexp_out_if import mexp_pkg::*; ();

    logic      valid;
    logic      ready;
    mexp_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

FILE: sv/modular_exponentiation_core.sv
// Modular exponentiation, base ** exponent mod modulus, right-to-left binary
// square-and-multiply on WIDTH-bit unsigned operands. One word is in flight at
// a time: operand.ready is high only while the core is idle. All modular
// products run on a single bit-serial double-and-add multiplier that consumes
// one multiplier bit per cycle. A word takes one product to reduce the base,
// then one squaring per exponent bit below the highest set bit and one
// multiplication per set exponent bit. Exponent zero returns 1, and zero
// modulus with a nonzero exponent returns 0 with zero_modulus_error set, each
// in the cycle after acceptance.
module modular_exponentiation_core import mexp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    mexp_in_if.sink    operand,
    mexp_out_if.source result
);

    state_t           state_reg, state_next;
    word_t            base_reg, base_next;
    word_t            acc_reg, acc_next;
    word_t            exp_reg, exp_next;
    word_t            mod_reg, mod_next;
    word_t            mplier_reg, mplier_next;
    word_t            prod_reg, prod_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            res_reg, res_next;
    logic             err_reg, err_next;

    logic             accept;
    logic             op_last;
    logic             exp_shr_zero;
    word_t            mcand;
    word_t            addend;
    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] mod_x1;
    logic [WIDTH+1:0] mod_x2;
    logic [WIDTH+1:0] red;
    word_t            prod_step;

    assign accept       = operand.valid && operand.ready;
    assign op_last      = (cnt_reg == LAST_BIT);
    assign exp_shr_zero = (exp_reg[WIDTH-1:1] == '0);

    // one double-and-add step: sum < 3m, reduce by 2m or m
    assign mcand  = (state_reg == ST_PREP) ? acc_reg : base_reg;
    assign addend = mplier_reg[WIDTH-1] ? mcand : '0;
    assign sum    = {1'b0, prod_reg, 1'b0} + {2'b00, addend};
    assign mod_x1 = {2'b00, mod_reg};
    assign mod_x2 = {1'b0, mod_reg, 1'b0};

    always_comb
    begin
        if (sum >= mod_x2)
        begin
            red = sum - mod_x2;
        end
        else if (sum >= mod_x1)
        begin
            red = sum - mod_x1;
        end
        else
        begin
            red = sum;
        end
    end

    assign prod_step = red[WIDTH-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((operand.data.exponent == '0) || (operand.data.modulus == '0))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP, ST_SQR:
            begin
                if (op_last)
                begin
                    state_next = exp_reg[0] ? ST_MUL : ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (op_last)
                begin
                    state_next = exp_shr_zero ? ST_DONE : ST_SQR;
                end
            end
            ST_DONE:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        base_next   = base_reg;
        acc_next    = acc_reg;
        exp_next    = exp_reg;
        mod_next    = mod_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        cnt_next    = cnt_reg;
        res_next    = res_reg;
        err_next    = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mod_next    = operand.data.modulus;
                    exp_next    = operand.data.exponent;
                    mplier_next = operand.data.base_value;
                    acc_next    = (operand.data.modulus == word_t'(1)) ? '0 : word_t'(1);
                    prod_next   = '0;
                    cnt_next    = '0;
                    res_next    = (operand.data.exponent == '0) ? word_t'(1) : '0;
                    err_next    = (operand.data.exponent != '0) &&
                                  (operand.data.modulus == '0);
                end
            end
            ST_PREP, ST_MUL, ST_SQR:
            begin
                prod_next   = prod_step;
                mplier_next = mplier_reg << 1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (op_last)
                begin
                    prod_next = '0;
                    cnt_next  = '0;
                    if (state_reg == ST_MUL)
                    begin
                        acc_next = prod_step;
                        res_next = prod_step;
                    end
                    else
                    begin
                        base_next = prod_step;
                    end
                    // load multiplier for the following product
                    if (state_next == ST_SQR)
                    begin
                        mplier_next = base_next;
                        exp_next    = exp_reg >> 1;
                    end
                    else if (state_next == ST_MUL)
                    begin
                        mplier_next = acc_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign operand.ready                  = (state_reg == ST_IDLE);
    assign result.valid                   = (state_reg == ST_DONE);
    assign result.data.power_result       = res_reg;
    assign result.data.zero_modulus_error = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        exp_reg    <= exp_next;
        mod_reg    <= mod_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
        err_reg    <= err_next;
    end

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        operand.ready |-> !result.valid)
        else $error("operand accepted while a result is pending");

    a_prod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP || state_reg == ST_MUL || state_reg == ST_SQR)
        |-> (prod_reg < mod_reg) && (acc_reg < mod_reg))
        else $error("partial product or accumulator not reduced");

    a_base_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_SQR) |-> (base_reg < mod_reg))
        else $error("base not reduced");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && err_reg) |-> (res_reg == '0))
        else $error("error word carries nonzero result");

    a_exp_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP || state_reg == ST_SQR) |-> (exp_reg != '0))
        else $error("exponent exhausted during a product");
`endif

endmodule
